>>> hw/rtl/pba_pkg.sv
// Shared constants, codes and handshake structs of the page bitmap allocator.
package pba_pkg;

    localparam int PAGE_COUNT     = 256;
    localparam int PAGE_SIZE_LOG2 = 12;

    localparam int IDX_W     = $clog2(PAGE_COUNT);
    localparam int ROVER_W   = $clog2(PAGE_COUNT + 1);
    localparam int GRP_W     = 16;
    localparam int GRP_N     = PAGE_COUNT / GRP_W;
    localparam int BIT_IDX_W = $clog2(GRP_W);
    localparam int GRP_IDX_W = IDX_W - BIT_IDX_W;

    // Byte span of the whole pool, one bit wider than an address.
    localparam logic [32:0] POOL_SPAN = 33'(PAGE_COUNT) << PAGE_SIZE_LOG2;

    typedef enum logic [1:0] {
        OP_ALLOC_SMALL  = 2'd0,
        OP_ALLOC_MEDIUM = 2'd1,
        OP_FREE         = 2'd2,
        OP_QUERY        = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NO_FREE = 2'd1,
        STS_OUTSIDE = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic grp_step;
        logic pick_step;
        logic bit_step;
        logic commit;
    } pba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_alloc;
    } pba_stat_t;

    typedef struct packed {
        logic        outside_pool;
        logic        medium_hit;
        logic        small_hit;
        logic [31:0] page_addr;
        status_t     status;
    } pba_result_t;

endpackage

>>> hw/rtl/pba_ctrl.sv
// Controller state machine of the page bitmap allocator.
module pba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  pba_pkg::pba_stat_t  stat,
    output pba_pkg::pba_cmd_t   cmd
);
    import pba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRP,
        S_PICK,
        S_BIT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   commit;

    // The result slot is free when it is empty or being drained this cycle.
    assign commit = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_GRP;
                end
            end
            S_GRP:
            begin
                state_next = stat.is_alloc ? S_PICK : S_DONE;
            end
            S_PICK:
            begin
                state_next = S_BIT;
            end
            S_BIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (commit)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready      = (state_reg == S_IDLE);
    assign m_tvalid      = m_tvalid_reg;
    assign cmd.load      = s_tvalid && (state_reg == S_IDLE);
    assign cmd.grp_step  = (state_reg == S_GRP);
    assign cmd.pick_step = (state_reg == S_PICK);
    assign cmd.bit_step  = (state_reg == S_BIT);
    assign cmd.commit    = commit;

endmodule

>>> hw/rtl/pba_datapath.sv
// Datapath of the page bitmap allocator: page bitmaps, rover, search and bounds logic.
module pba_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [31:0]           cfg_wdata,
    input  pba_pkg::op_t          in_op,
    input  logic [31:0]           in_addr,
    input  pba_pkg::pba_cmd_t     cmd,
    output pba_pkg::pba_stat_t    stat,
    output pba_pkg::pba_result_t  result
);
    import pba_pkg::*;

    function automatic logic [BIT_IDX_W-1:0] first_bit(input logic [GRP_W-1:0] v);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = GRP_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [GRP_IDX_W-1:0] first_grp(input logic [GRP_N-1:0] v);
        logic [GRP_IDX_W-1:0] pos;
        pos = '0;
        for (int i = GRP_N - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = GRP_IDX_W'(i);
            end
        end
        return pos;
    endfunction

    // Persistent state.
    logic [31:0]           pool_base_reg;
    logic [PAGE_COUNT-1:0] free_map_reg;
    logic [PAGE_COUNT-1:0] free_map_next;
    logic [PAGE_COUNT-1:0] small_map_reg;
    logic [PAGE_COUNT-1:0] small_map_next;
    logic [ROVER_W-1:0]    rover_reg;
    logic [ROVER_W-1:0]    rover_next;

    // Per-request working registers.
    op_t                   op_reg;
    logic [31:0]           addr_reg;
    logic [GRP_N-1:0]      fwd_any_reg;
    logic [GRP_N-1:0]      all_any_reg;
    logic [GRP_IDX_W-1:0]  grp_reg;
    logic                  use_fwd_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  in_pool_reg;
    logic [IDX_W-1:0]      loc_idx_reg;
    pba_result_t           res_reg;
    pba_result_t           res_next;

    logic [IDX_W-1:0]      start;
    logic [PAGE_COUNT-1:0] fwd_mask;
    logic [GRP_N-1:0]      fwd_any;
    logic [GRP_N-1:0]      all_any;
    logic [GRP_W-1:0]      word;
    logic [32:0]           diff;
    logic [IDX_W-1:0]      commit_idx;
    logic [31:0]           page_addr;

    // A rover at the end of the pool starts the search at page zero.
    assign start = (rover_reg >= ROVER_W'(PAGE_COUNT)) ? '0 : rover_reg[IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < PAGE_COUNT; i++)
        begin
            fwd_mask[i] = (IDX_W'(i) >= start);
        end
        for (int g = 0; g < GRP_N; g++)
        begin
            fwd_any[g] = |(free_map_reg[g*GRP_W +: GRP_W] & fwd_mask[g*GRP_W +: GRP_W]);
            all_any[g] = |free_map_reg[g*GRP_W +: GRP_W];
        end
    end

    always_comb
    begin
        word = free_map_reg[{grp_reg, {BIT_IDX_W{1'b0}}} +: GRP_W];
        if (use_fwd_reg)
        begin
            word = word & fwd_mask[{grp_reg, {BIT_IDX_W{1'b0}}} +: GRP_W];
        end
    end

    assign diff = {1'b0, addr_reg} - {1'b0, pool_base_reg};

    assign stat.is_alloc = op_reg inside {OP_ALLOC_SMALL, OP_ALLOC_MEDIUM};

    assign commit_idx = stat.is_alloc ? idx_reg : loc_idx_reg;
    assign page_addr  = pool_base_reg + (32'(commit_idx) << PAGE_SIZE_LOG2);

    always_comb
    begin
        free_map_next  = free_map_reg;
        small_map_next = small_map_reg;
        rover_next     = rover_reg;
        res_next       = res_reg;
        if (cmd.commit)
        begin
            res_next = '0;
            case (op_reg)
                OP_ALLOC_SMALL, OP_ALLOC_MEDIUM:
                begin
                    if (found_reg)
                    begin
                        free_map_next[idx_reg]  = 1'b0;
                        small_map_next[idx_reg] = (op_reg == OP_ALLOC_SMALL);
                        rover_next              = ROVER_W'(idx_reg) + 1'b1;
                        res_next.page_addr      = page_addr;
                    end
                    else
                    begin
                        res_next.status = STS_NO_FREE;
                    end
                end
                OP_FREE:
                begin
                    if (in_pool_reg)
                    begin
                        free_map_next[loc_idx_reg] = 1'b1;
                        rover_next                 = ROVER_W'(loc_idx_reg);
                    end
                    else
                    begin
                        res_next.status       = STS_OUTSIDE;
                        res_next.outside_pool = 1'b1;
                    end
                end
                default:
                begin
                    if (in_pool_reg)
                    begin
                        res_next.page_addr  = page_addr;
                        res_next.small_hit  = small_map_reg[loc_idx_reg];
                        res_next.medium_hit = !small_map_reg[loc_idx_reg];
                    end
                    else
                    begin
                        res_next.outside_pool = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            free_map_reg  <= '1;
            small_map_reg <= '0;
            rover_reg     <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                pool_base_reg <= cfg_wdata;
            end
            free_map_reg  <= free_map_next;
            small_map_reg <= small_map_next;
            rover_reg     <= rover_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            addr_reg <= in_addr;
        end
        if (cmd.grp_step)
        begin
            fwd_any_reg <= fwd_any;
            all_any_reg <= all_any;
            in_pool_reg <= (diff < POOL_SPAN);
            loc_idx_reg <= diff[PAGE_SIZE_LOG2 +: IDX_W];
        end
        if (cmd.pick_step)
        begin
            use_fwd_reg <= |fwd_any_reg;
            found_reg   <= |all_any_reg;
            grp_reg     <= (|fwd_any_reg) ? first_grp(fwd_any_reg) : first_grp(all_any_reg);
        end
        if (cmd.bit_step)
        begin
            idx_reg <= {grp_reg, first_bit(word)};
        end
        res_reg <= res_next;
    end

    assign result = res_reg;

    a_rover_range: assert property (@(posedge clk) disable iff (!rst_n)
        rover_reg <= ROVER_W'(PAGE_COUNT))
        else $error("rover beyond end of pool");

    a_pick_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bit_step && found_reg |=> free_map_reg[idx_reg])
        else $error("search picked a page that is not free");

    a_alloc_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && stat.is_alloc && found_reg |=>
            !free_map_reg[$past(idx_reg)] && (rover_reg == ROVER_W'($past(idx_reg)) + 1'b1))
        else $error("allocation did not claim the page or move the rover");

    a_free_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (op_reg == OP_FREE) && in_pool_reg |=>
            free_map_reg[$past(loc_idx_reg)] && (rover_reg == ROVER_W'($past(loc_idx_reg))))
        else $error("free did not release the page or move the rover");

endmodule

>>> hw/rtl/page_bitmap_allocator_unit.sv
// Top level of the next-fit page bitmap allocator.
//
//  Channel  | Direction | Signals                          | Carries
//  ---------+-----------+----------------------------------+-------------------------------
//  s_*      | in        | s_tvalid s_tready s_tuser s_tdata| one request: op, addr
//  m_*      | out       | m_tvalid m_tready m_tdata        | one result per request
//  cfg_*    | in        | cfg_wen cfg_wdata                | pool_base register write
//
// An allocation runs through these steps from acceptance to result: taking the request,
// reducing the free bitmap to per-group flags, picking a group, encoding the bit inside
// that group, and updating the bitmaps and loading the result register.
// Free and query requests skip the group pick and bit encode steps.
// Reset leaves every page free, every class bit medium, the rover at page zero and
// pool_base at zero. A stalled result holds in the output register; the next request
// is taken meanwhile and its processing waits at the final step until the slot drains.
module page_bitmap_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: pool_base, byte address of the first page.
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic [31:0] s_tdata,   // [31:0] addr
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [33:2] page_addr, [34] small_hit,
                                   // [35] medium_hit, [36] outside_pool, [39:37] zero
);
    import pba_pkg::*;

    pba_cmd_t    cmd;
    pba_stat_t   stat;
    pba_result_t result;

    // The controller sequences each request through the search and update steps.
    pba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the bitmaps, the rover, the pool base and the result register.
    pba_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_op     (op_t'(s_tuser)),
        .in_addr   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

    // Pack the result fields from the lowest bit up, padded to whole bytes.
    assign m_tdata = {3'b000, result.outside_pool, result.medium_hit, result.small_hit,
                      result.page_addr, result.status};

endmodule

>>> sim/page_bitmap_allocator_unit_test.sv
// Self-checking testbench for the next-fit page bitmap allocator top level.
module page_bitmap_allocator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;

    localparam int          PAGE_BYTES   = 1 << PAGE_SIZE_LOG2;
    localparam int          DRAIN_CYCLES = 8;        // extra wait after the last result
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [31:0] TOP_PAGE     = 32'hFFFF_FFFF << PAGE_SIZE_LOG2;

    // Clock, reset and the block's ports. Every input starts at a known value.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser   = '0;   // [1:0] op
    logic [31:0] s_tdata   = '0;   // [31:0] addr
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // [1:0] status, [33:2] page_addr, [34] small_hit,
                                   // [35] medium_hit, [36] outside_pool, [39:37] zero

    // Our own copy of the allocator state, updated as each request is accepted.
    logic [PAGE_COUNT-1:0] page_free  = '1;
    logic [PAGE_COUNT-1:0] page_small = '0;
    int                    next_fit   = 0;    // search start, 0..PAGE_COUNT
    logic [31:0]           pool_start = '0;

    // Expected results in request order, and the bookkeeping around them.
    pba_result_t pending_results[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          sender_gaps    = 1'b1;
    bit          receiver_stalls = 1'b1;
    int          long_hold_cycles = 0;

    page_bitmap_allocator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Byte address of a page. The sum wraps past the top of memory just as the
    // block's 32-bit page address does.
    function automatic logic [31:0] page_address(int idx);
        return pool_start + (32'(idx) << PAGE_SIZE_LOG2);
    endfunction

    // The pool end is formed one bit wider so that a pool near the top of memory
    // does not wrap its bound.
    function automatic bit in_pool(logic [31:0] addr, output int idx);
        logic [32:0] pool_end;
        pool_end = {1'b0, pool_start} + POOL_SPAN;
        idx = 0;
        if (addr < pool_start || {1'b0, addr} >= pool_end)
            return 1'b0;
        idx = int'((addr - pool_start) >> PAGE_SIZE_LOG2);
        return 1'b1;
    endfunction

    // Applies one accepted request to the state copy and returns the result that
    // the block has to produce for it.
    function automatic pba_result_t compute_page_result(op_t op, logic [31:0] addr);
        pba_result_t res;
        int          start;
        int          probe;
        int          idx;
        res = '0;
        res.status = STS_OK;
        case (op)
            OP_ALLOC_SMALL, OP_ALLOC_MEDIUM:
            begin
                // Next fit: scan from the rover to the end, then wrap from page zero.
                // A rover sitting one past the last page makes the forward part empty.
                res.status = STS_NO_FREE;
                start = (next_fit >= PAGE_COUNT) ? 0 : next_fit;
                for (int k = 0; k < PAGE_COUNT; k++)
                begin
                    probe = (start + k) % PAGE_COUNT;
                    if (page_free[probe])
                    begin
                        page_free[probe]  = 1'b0;
                        page_small[probe] = (op == OP_ALLOC_SMALL);
                        next_fit          = probe + 1;
                        res.status        = STS_OK;
                        res.page_addr     = page_address(probe);
                        break;
                    end
                end
            end
            OP_FREE:
            begin
                // Freeing an already free page still moves the rover; the class
                // bit is left stale on purpose.
                if (in_pool(addr, idx))
                begin
                    page_free[idx] = 1'b1;
                    next_fit       = idx;
                end
                else
                begin
                    res.status       = STS_OUTSIDE;
                    res.outside_pool = 1'b1;
                end
            end
            default:
            begin
                if (in_pool(addr, idx))
                begin
                    res.page_addr  = page_address(idx);
                    res.small_hit  = page_small[idx];
                    res.medium_hit = !page_small[idx];
                end
                else
                    res.outside_pool = 1'b1;
            end
        endcase
        return res;
    endfunction

    // Idle lengths for both sides: mostly none or short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch in %s: expected 0x%08h, got 0x%08h", what, want, got);
    endtask

    // Offers one request and waits for the handshake. Valid stays high after the
    // acceptance, so a back-to-back request needs no second assignment in a step.
    // The caller always enters just after a rising edge.
    task automatic send_request(op_t op, logic [31:0] addr);
        int gap;
        gap = sender_gaps ? idle_length() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= addr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(compute_page_result(op, addr));
    endtask

    // Stops offering and waits until every expected result has come back, plus a
    // few cycles so that the block is surely idle.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only called while the block is idle. The state copy takes the new base at
    // the same edge as the block.
    task automatic write_pool_base(logic [31:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen    <= 1'b0;
        pool_start = value;
    endtask

    // Address for a free or query. Most land inside the pool; a free prefers a page
    // that is currently allocated so that allocations and releases interleave. The
    // rest are raw random addresses and addresses right at the pool bounds.
    function automatic logic [31:0] pick_address(bit want_allocated);
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (r < 12)
            return $urandom;
        if (r < 18)
        begin
            case ($urandom_range(0, 3))
                0:       return pool_start - 32'd1;
                1:       return pool_start;
                2:       return pool_start + POOL_SPAN[31:0] - 32'd1;
                default: return pool_start + POOL_SPAN[31:0];
            endcase
        end
        idx = $urandom_range(0, PAGE_COUNT - 1);
        if (want_allocated)
        begin
            for (int k = 0; k < PAGE_COUNT; k++)
            begin
                if (!page_free[(idx + k) % PAGE_COUNT])
                begin
                    idx = (idx + k) % PAGE_COUNT;
                    break;
                end
            end
        end
        return page_address(idx) + 32'($urandom_range(0, PAGE_BYTES - 1));
    endfunction

    // A run of random requests. alloc_pct sets the share of allocations; what is
    // left splits into releases and queries.
    task automatic run_random_requests(int count, int alloc_pct);
        int   r;
        op_t  op;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
                op = $urandom_range(0, 1) ? OP_ALLOC_SMALL : OP_ALLOC_MEDIUM;
            else if (r < alloc_pct + (100 - alloc_pct) * 6 / 10)
                op = OP_FREE;
            else
                op = OP_QUERY;
            // Allocations ignore the address, so it carries random bits there.
            if (op == OP_FREE || op == OP_QUERY)
                send_request(op, pick_address(op == OP_FREE));
            else
                send_request(op, $urandom);
        end
    endtask

    // Right after reset every page is free and marked medium.
    task automatic test_reset_state();
        send_request(OP_QUERY, 32'h0000_0ABC);
        send_request(OP_QUERY, 32'hFFFF_FFFF);
    endtask

    // Both allocation kinds, and queries on both sides of the first page boundary, at
    // the last byte and just past the end of the pool.
    task automatic test_alloc_and_query();
        send_request(OP_ALLOC_SMALL, 32'hFFFF_FFFF);
        send_request(OP_ALLOC_MEDIUM, 32'h0000_0000);
        send_request(OP_QUERY, 32'h0000_0FFF);
        send_request(OP_QUERY, 32'h0000_1000);
        send_request(OP_QUERY, POOL_SPAN[31:0] - 32'd1);
        send_request(OP_QUERY, POOL_SPAN[31:0]);
    endtask

    // Releases in the pool, a double release, releases outside the pool, and a
    // reallocation that picks up the rover left by a release.
    task automatic test_release_paths();
        send_request(OP_FREE, 32'h0000_0010);
        send_request(OP_FREE, 32'h0000_0FF0);
        send_request(OP_FREE, POOL_SPAN[31:0]);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_ALLOC_MEDIUM, 32'h5555_5555);
        send_request(OP_QUERY, 32'h0000_0000);
    endtask

    // Rover on the last page, then one past it, so the next search wraps to zero.
    // Releasing the last page afterwards leaves its small mark stale.
    task automatic test_rover_wrap();
        send_request(OP_FREE, POOL_SPAN[31:0] - PAGE_BYTES);
        send_request(OP_ALLOC_SMALL, 32'hAAAA_AAAA);
        send_request(OP_ALLOC_SMALL, 32'h0000_0000);
        send_request(OP_FREE, POOL_SPAN[31:0] - 32'd1);
        send_request(OP_QUERY, POOL_SPAN[31:0] - 32'd1);
    endtask

    // A pool that starts on the topmost page: page addresses past 2^32 wrap, while
    // the bound check must not. Then a base of all ones, which is not page aligned.
    task automatic test_top_of_memory();
        wait_until_idle();
        write_pool_base(TOP_PAGE);
        send_request(OP_QUERY, 32'hFFFF_FFFF);
        send_request(OP_ALLOC_SMALL, 32'h0000_0000);
        send_request(OP_ALLOC_MEDIUM, 32'h0000_0000);
        send_request(OP_QUERY, 32'h0000_0000);
        send_request(OP_FREE, 32'h0000_0000);
        wait_until_idle();
        write_pool_base(32'hFFFF_FFFF);
        send_request(OP_QUERY, 32'hFFFF_FFFF);
        send_request(OP_QUERY, 32'hFFFF_FFFE);
    endtask

    // Allocation-heavy traffic drains the pool, so many requests find no free page.
    task automatic test_pool_exhaustion();
        wait_until_idle();
        write_pool_base(32'h4000_0000);
        run_random_requests(350, 85);
    endtask

    // Release-heavy traffic on a random page-aligned base.
    task automatic test_release_heavy();
        wait_until_idle();
        write_pool_base($urandom & TOP_PAGE);
        run_random_requests(350, 25);
    endtask

    // Back to back on both sides, with no idle cycles at all.
    task automatic test_streaming();
        wait_until_idle();
        write_pool_base(32'h0000_0000);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        run_random_requests(350, 55);
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the
    // block fills and stalls its input. The pool runs past the top of memory.
    task automatic test_backpressure();
        wait_until_idle();
        write_pool_base(32'hFFF8_0000);
        sender_gaps = 1'b0;
        run_random_requests(20, 60);
        long_hold_cycles = 300;
        run_random_requests(80, 60);
        sender_gaps = 1'b1;
        run_random_requests(250, 60);
    endtask

    // A random base that is usually not page aligned.
    task automatic test_unaligned_base();
        wait_until_idle();
        write_pool_base($urandom);
        run_random_requests(350, 50);
    endtask

    // Receiver: a long hold when one is asked for, otherwise random stalls unless
    // they are switched off.
    initial
    begin
        int stall_left;
        int gap;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                long_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!receiver_stalls)
                m_tready <= 1'b1;
            else
            begin
                gap = idle_length();
                m_tready <= (gap == 0);
                stall_left = (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    // Result checker. Each accepted result is matched against the oldest one
    // expected, field by field; the pad bits above the fields must stay zero.
    always @(posedge clk)
    begin
        pba_result_t got;
        pba_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = pba_result_t'(m_tdata[36:0]);
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", '0, m_tdata[31:0]);
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(want.status), 32'(got.status));
                if (got.page_addr != want.page_addr)
                    report_mismatch("page_addr", want.page_addr, got.page_addr);
                if (got.small_hit != want.small_hit)
                    report_mismatch("small_hit", 32'(want.small_hit), 32'(got.small_hit));
                if (got.medium_hit != want.medium_hit)
                    report_mismatch("medium_hit", 32'(want.medium_hit), 32'(got.medium_hit));
                if (got.outside_pool != want.outside_pool)
                    report_mismatch("outside_pool", 32'(want.outside_pool),
                                    32'(got.outside_pool));
                if (m_tdata[39:37] != 3'b000)
                    report_mismatch("pad bits", '0, 32'(m_tdata[39:37]));
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("page_bitmap_allocator_unit_test: done, errors");
        $finish;
    end

    // Test sequence: reset once, a short directed part, then random phases over
    // several pool bases, each started only once the block is idle.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_pool_base(32'h0000_0000);
        test_reset_state();
        test_alloc_and_query();
        test_release_paths();
        test_rover_wrap();
        test_top_of_memory();

        test_pool_exhaustion();
        test_release_heavy();
        test_streaming();
        test_backpressure();
        test_unaligned_base();

        wait_until_idle();
        if (mismatch_count == 0)
            $display("page_bitmap_allocator_unit_test: done, clean");
        else
            $display("page_bitmap_allocator_unit_test: done, errors");
        $finish;
    end

endmodule
